[src/rycc_pkg.sv]
// Shared types, coefficient constants and helper functions of the color converter.
// Used by every module of the converter; depends on nothing.
package rycc_pkg;

  // register indexes of the configuration port
  localparam logic [7:0] REG_DIRECTION  = 8'd0;
  localparam logic [7:0] REG_BLUE_FIRST = 8'd1;

  localparam int NUM_COEF  = 13;
  localparam int PROD_W    = 29;
  localparam int SUM_W     = 32;
  localparam int FRAC_BITS = 20;

  // coefficient indexes: forward luma, forward chroma, inverse terms
  localparam logic [3:0] COEF_Y_R   = 4'd0;
  localparam logic [3:0] COEF_Y_G   = 4'd1;
  localparam logic [3:0] COEF_Y_B   = 4'd2;
  localparam logic [3:0] COEF_CR_R  = 4'd3;
  localparam logic [3:0] COEF_CR_G  = 4'd4;
  localparam logic [3:0] COEF_CR_B  = 4'd5;
  localparam logic [3:0] COEF_CB_R  = 4'd6;
  localparam logic [3:0] COEF_CB_G  = 4'd7;
  localparam logic [3:0] COEF_CB_B  = 4'd8;
  localparam logic [3:0] COEF_R_CR  = 4'd9;
  localparam logic [3:0] COEF_G_CR  = 4'd10;
  localparam logic [3:0] COEF_G_CB  = 4'd11;
  localparam logic [3:0] COEF_B_CB  = 4'd12;

  // single-precision mantissas, value = mant * 2^-(shift + 20)
  localparam logic [23:0] COEF_MANT [NUM_COEF] = '{
    24'd10032775, 24'd9848226,  24'd15300821,
    24'd16770941, 24'd14043570, 24'd10909485,
    24'd11316970, 24'd11108799, 24'd16767284,
    24'd11769217, 24'd11978932, 24'd11542725, 24'd14873002
  };
  localparam logic [2:0] COEF_SHIFT [NUM_COEF] = '{
    3'd5, 3'd4, 3'd7,
    3'd5, 3'd5, 3'd7,
    3'd6, 3'd5, 3'd5,
    3'd3, 3'd4, 3'd5, 3'd3
  };

  // inverse offsets trunc(k * 128 * 2^20) and the chroma bias
  localparam logic [27:0] OFS_R_CR   = 28'd188307472;
  localparam logic [27:0] OFS_G_CR   = 28'd95831456;
  localparam logic [27:0] OFS_G_CB   = 28'd46170900;
  localparam logic [27:0] OFS_B_CB   = 28'd237968032;
  localparam logic [27:0] OFS_CHROMA = 28'd134217728;

  // control that travels with each pixel
  typedef struct packed {
    logic inverse;
    logic blue_first;
    logic frame_end;
  } ctrl_t;

  // first stage: all coefficient products
  typedef struct packed {
    logic [NUM_COEF-1:0][PROD_W-1:0] prod;
    logic [7:0]                      luma;
    ctrl_t                           ctrl;
  } prod_t;

  // second stage: the three fixed-point sums
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_b;
    logic signed [SUM_W-1:0] sum_c;
    ctrl_t                   ctrl;
  } sum_t;

  // trunc(j * c * 2^20) for coefficient t
  function automatic logic [PROD_W-1:0] coef_product(input logic [3:0] t,
                                                     input logic [7:0] j);
    logic [31:0] p;
    p = 32'(j) * 32'(COEF_MANT[t]);
    p = p >> COEF_SHIFT[t];
    return p[PROD_W-1:0];
  endfunction

  // floor shift by the fraction bits and clamp to 0..255
  function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    logic signed [11:0]      v;
    sh = s >>> FRAC_BITS;
    v  = sh[11:0];
    if (v < 0) return 8'd0;
    else if (v > 12'sd255) return 8'd255;
    else return v[7:0];
  endfunction

endpackage

[src/rgb_ycbcr_color_converter_unit.sv]
// Top level of the RGB / full-range BT.601 Y,Cr,Cb color converter.
// Depends on rycc_pkg, rycc_product_stage, rycc_sum_stage and rycc_clamp_stage.
//
// Pixels enter on the input channel (in_valid/in_ready, comp_a..comp_c and
// frame_end) and leave on the output channel (out_valid/out_ready, out_a..out_c
// and frame_end_out), one result per pixel, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// direction (0 rgb to Y,Cr,Cb, 1 the inverse), index 1 is blue_first (rgb side
// ordered B,G,R). Only bit 0 of cfg_data is used; other indexes are ignored.
// cfg_ready is always high; write only while no pixel is in flight.
// A pixel accepted at the input passes through the three register stages in order
// (products, sums, clamp and output register) before it is on the outputs and can
// be taken.
// Throughput: one pixel per cycle, sustained while out_ready stays high.
// When the receiver stalls, each stage holds its data and the pipeline fills;
// in_ready falls only once all three stages are occupied. Nothing is dropped.
// Reset (rst, synchronous): the pipeline empties and both registers return to 0.
module rgb_ycbcr_color_converter_unit import rycc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] comp_a,
  input  logic [7:0] comp_b,
  input  logic [7:0] comp_c,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_a,
  output logic [7:0] out_b,
  output logic [7:0] out_c,
  output logic       frame_end_out
);

  logic  direction;
  logic  blue_first;
  ctrl_t ctrl_in;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_data;
  logic  sum_valid;
  logic  sum_ready;
  sum_t  sum_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      blue_first <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DIRECTION) begin
        direction <= cfg_data[0];
      end else if (cfg_index == REG_BLUE_FIRST) begin
        blue_first <= cfg_data[0];
      end
    end
  end

  // per-pixel control
  always_comb begin
    ctrl_in.inverse    = direction;
    ctrl_in.blue_first = blue_first;
    ctrl_in.frame_end  = frame_end;
  end

  rycc_product_stage u_product (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .comp_a      (comp_a),
    .comp_b      (comp_b),
    .comp_c      (comp_c),
    .ctrl_in     (ctrl_in),
    .stage_valid (prod_valid),
    .stage_ready (prod_ready),
    .stage_data  (prod_data)
  );

  rycc_sum_stage u_sum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (prod_valid),
    .in_ready    (prod_ready),
    .in_data     (prod_data),
    .stage_valid (sum_valid),
    .stage_ready (sum_ready),
    .stage_data  (sum_data)
  );

  rycc_clamp_stage u_clamp (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (sum_valid),
    .in_ready      (sum_ready),
    .in_data       (sum_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_a         (out_a),
    .out_b         (out_b),
    .out_c         (out_c),
    .frame_end_out (frame_end_out)
  );

endmodule

[src/rycc_product_stage.sv]
// First pipeline stage: component selection and coefficient products.
// Depends on rycc_pkg.
module rycc_product_stage import rycc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] comp_a,
  input  logic [7:0] comp_b,
  input  logic [7:0] comp_c,
  input  ctrl_t      ctrl_in,
  output logic       stage_valid,
  input  logic       stage_ready,
  output prod_t      stage_data
);

  logic       vld;
  prod_t      data;
  prod_t      data_next;
  logic [7:0] red;
  logic [7:0] blue;

  assign in_ready    = !vld || stage_ready;
  assign stage_valid = vld;
  assign stage_data  = data;

  // rgb side order
  always_comb begin
    red  = ctrl_in.blue_first ? comp_c : comp_a;
    blue = ctrl_in.blue_first ? comp_a : comp_c;
  end

  // constant products
  always_comb begin
    data_next.prod[COEF_Y_R]  = coef_product(COEF_Y_R, red);
    data_next.prod[COEF_Y_G]  = coef_product(COEF_Y_G, comp_b);
    data_next.prod[COEF_Y_B]  = coef_product(COEF_Y_B, blue);
    data_next.prod[COEF_CR_R] = coef_product(COEF_CR_R, red);
    data_next.prod[COEF_CR_G] = coef_product(COEF_CR_G, comp_b);
    data_next.prod[COEF_CR_B] = coef_product(COEF_CR_B, blue);
    data_next.prod[COEF_CB_R] = coef_product(COEF_CB_R, red);
    data_next.prod[COEF_CB_G] = coef_product(COEF_CB_G, comp_b);
    data_next.prod[COEF_CB_B] = coef_product(COEF_CB_B, blue);
    data_next.prod[COEF_R_CR] = coef_product(COEF_R_CR, comp_b);
    data_next.prod[COEF_G_CR] = coef_product(COEF_G_CR, comp_b);
    data_next.prod[COEF_G_CB] = coef_product(COEF_G_CB, comp_c);
    data_next.prod[COEF_B_CB] = coef_product(COEF_B_CB, comp_c);
    data_next.luma            = comp_a;
    data_next.ctrl            = ctrl_in;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

[src/rycc_sum_stage.sv]
// Second pipeline stage: forward or inverse fixed-point sums.
// Depends on rycc_pkg.
module rycc_sum_stage import rycc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_data,
  output logic  stage_valid,
  input  logic  stage_ready,
  output sum_t  stage_data
);

  logic                    vld;
  sum_t                    data;
  sum_t                    data_next;
  logic signed [SUM_W-1:0] p [NUM_COEF];
  logic signed [SUM_W-1:0] luma_fx;
  logic signed [SUM_W-1:0] bias;

  assign in_ready    = !vld || stage_ready;
  assign stage_valid = vld;
  assign stage_data  = data;

  // widen products to signed sums
  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      p[i] = SUM_W'(in_data.prod[i]);
    end
    luma_fx = SUM_W'({in_data.luma, FRAC_BITS'(0)});
    bias    = SUM_W'(OFS_CHROMA);
  end

  // three sums, selected by direction
  always_comb begin
    data_next.ctrl = in_data.ctrl;
    if (in_data.ctrl.inverse) begin
      data_next.sum_a = luma_fx + p[COEF_R_CR] - SUM_W'(OFS_R_CR);
      data_next.sum_b = luma_fx - p[COEF_G_CR] + SUM_W'(OFS_G_CR)
                        - p[COEF_G_CB] + SUM_W'(OFS_G_CB);
      data_next.sum_c = luma_fx + p[COEF_B_CB] - SUM_W'(OFS_B_CB);
    end else begin
      data_next.sum_a = p[COEF_Y_R] + p[COEF_Y_G] + p[COEF_Y_B];
      data_next.sum_b = p[COEF_CR_R] - p[COEF_CR_G] - p[COEF_CR_B] + bias;
      data_next.sum_c = p[COEF_CB_B] - p[COEF_CB_R] - p[COEF_CB_G] + bias;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

[src/rycc_clamp_stage.sv]
// Last pipeline stage: floor shift, saturation, rgb order and output register.
// Depends on rycc_pkg.
module rycc_clamp_stage import rycc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sum_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_a,
  output logic [7:0] out_b,
  output logic [7:0] out_c,
  output logic       frame_end_out
);

  logic       vld;
  logic [7:0] res_a;
  logic [7:0] res_b;
  logic [7:0] res_c;
  logic [7:0] sat_a;
  logic [7:0] sat_c;
  logic       fe;
  logic       swap;

  assign in_ready      = !vld || out_ready;
  assign out_valid     = vld;
  assign out_a         = res_a;
  assign out_b         = res_b;
  assign out_c         = res_c;
  assign frame_end_out = fe;

  // clamp and swap red and blue on the inverse path when blue_first is set
  always_comb begin
    sat_a = sat8(in_data.sum_a);
    sat_c = sat8(in_data.sum_c);
    swap  = in_data.ctrl.inverse && in_data.ctrl.blue_first;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      res_a <= swap ? sat_c : sat_a;
      res_b <= sat8(in_data.sum_b);
      res_c <= swap ? sat_a : sat_c;
      fe    <= in_data.ctrl.frame_end;
    end
  end

endmodule

[src/rycc_checker.sv]
// Port-level checks of the color converter, attached to the top level by bind.
// Depends on rgb_ycbcr_color_converter_unit.
module rycc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_a,
  input logic [7:0] out_b,
  input logic [7:0] out_c,
  input logic       frame_end_out
);

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b)
                                && $stable(out_c) && $stable(frame_end_out))
    else $error("stalled result changed");

  // no result without a request in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without request");

  // at most three requests in the pipeline
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("more requests in flight than stages");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind rgb_ycbcr_color_converter_unit rycc_checker u_rycc_checker (.*);
